### rtl/hcb_pkg.sv
// Shared types, sizes and datapath command codes for the Huffman code builder.
// Used by every module of the block except hcb_ram; depends on nothing.
`default_nettype none

package hcb_pkg;

  // Sizes
  localparam int MAX_SYMBOLS = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int IDX_W       = 5;    // heap slot / stack entry index
  localparam int CNT_W       = 6;    // counts that reach MAX_SYMBOLS
  localparam int NODE_W      = 6;    // node number, leaves first
  localparam int SUM_W       = 22;   // node weight, wide enough for any sum
  localparam int CODE_W      = 31;   // deepest leaf of a 32-symbol tree
  localparam int LEN_W       = 5;
  localparam int CHILD_DEPTH = MAX_SYMBOLS - 1;

  typedef struct packed {
    logic [15:0] weight;
    logic        final_symbol;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  symbol;
    logic [62:0] code_bits;
    logic [5:0]  code_len;
    logic        overflow;
    logic        end_of_codes;
  } out_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [SUM_W-1:0]  weight;
  } heap_ent_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } walk_ent_t;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
  } child_ent_t;

  // Datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
  localparam logic [OP_W-1:0] OP_DROP     = 5'd2;
  localparam logic [OP_W-1:0] OP_UP       = 5'd3;
  localparam logic [OP_W-1:0] OP_UP_CMP   = 5'd4;
  localparam logic [OP_W-1:0] OP_POP0     = 5'd5;
  localparam logic [OP_W-1:0] OP_POP1     = 5'd6;
  localparam logic [OP_W-1:0] OP_POP2     = 5'd7;
  localparam logic [OP_W-1:0] OP_DN       = 5'd8;
  localparam logic [OP_W-1:0] OP_DN_L     = 5'd9;
  localparam logic [OP_W-1:0] OP_DN_R     = 5'd10;
  localparam logic [OP_W-1:0] OP_MERGE    = 5'd11;
  localparam logic [OP_W-1:0] OP_WK_START = 5'd12;
  localparam logic [OP_W-1:0] OP_EMIT     = 5'd13;
  localparam logic [OP_W-1:0] OP_CHILD_RD = 5'd14;
  localparam logic [OP_W-1:0] OP_WK_CH    = 5'd15;
  localparam logic [OP_W-1:0] OP_WK_POP   = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            first;   // pop result goes to the left-child holder
  } dp_cmd_t;

  typedef struct packed {
    logic sym_full;
    logic i_zero;
    logic up_less;
    logic cnt_gt1;
    logic cnt_zero;
    logic l_out;
    logic dn_stop;
    logic leaf;
    logic sp_zero;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/hcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the heap, child table and walk stack.
`default_nettype none

module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/hcb_dp.sv
// Datapath: heap, child table and walk stack memories, counters, output register.
// Depends on hcb_pkg and hcb_ram; driven by hcb_ctrl commands.
`default_nettype none

module hcb_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire hcb_pkg::in_item_t   in_data,
  input  wire hcb_pkg::dp_cmd_t    cmd,
  input  wire logic                out_stall,
  output hcb_pkg::dp_stat_t        stat,
  output logic                     out_valid,
  output hcb_pkg::out_item_t       out_data
);

  // Control registers
  logic [hcb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [hcb_pkg::CNT_W-1:0] sym_r, sym_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Payload registers
  logic [hcb_pkg::CNT_W-1:0]  next_r, next_nxt;
  logic [hcb_pkg::IDX_W-1:0]  i_r, i_nxt;
  hcb_pkg::heap_ent_t         x_r, x_nxt;
  hcb_pkg::heap_ent_t         a_r, a_nxt;
  hcb_pkg::heap_ent_t         top_r, top_nxt;
  hcb_pkg::heap_ent_t         lv_r, lv_nxt;
  logic [hcb_pkg::NODE_W-1:0] n_r, n_nxt;
  logic [hcb_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [hcb_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [hcb_pkg::CNT_W-1:0]  sp_r, sp_nxt;
  hcb_pkg::out_item_t         out_data_r, out_data_nxt;

  // Memory ports
  logic                       h_we;
  logic [hcb_pkg::IDX_W-1:0]  h_waddr, h_raddr;
  hcb_pkg::heap_ent_t         h_wdata, h_rdata;
  logic                       c_we;
  logic [hcb_pkg::IDX_W-1:0]  c_waddr, c_raddr;
  hcb_pkg::child_ent_t        c_wdata, c_rdata;
  logic                       s_we;
  logic [hcb_pkg::IDX_W-1:0]  s_waddr, s_raddr;
  hcb_pkg::walk_ent_t         s_wdata, s_rdata;

  // Index arithmetic
  logic [hcb_pkg::IDX_W-1:0]  parent;
  logic [hcb_pkg::CNT_W-1:0]  lidx, ridx;
  logic [hcb_pkg::CNT_W-1:0]  child_rel, merge_rel, sp_dec;
  logic                       take_l, take_r;
  logic [hcb_pkg::SUM_W-1:0]  minw;
  logic                       out_free;

  assign parent    = (i_r - hcb_pkg::IDX_W'(1)) >> 1;
  assign lidx      = {i_r, 1'b1};
  assign ridx      = lidx + hcb_pkg::CNT_W'(1);
  assign child_rel = hcb_pkg::CNT_W'(n_r) - sym_r;
  assign merge_rel = next_r - sym_r;
  assign sp_dec    = sp_r - hcb_pkg::CNT_W'(1);
  assign out_free  = !out_valid_r || !out_stall;

  // Sift-down child choice: strict compares, left wins a tie
  assign take_l = lv_r.weight < x_r.weight;
  assign minw   = take_l ? lv_r.weight : x_r.weight;
  assign take_r = (ridx < cnt_r) && (h_rdata.weight < minw);

  // Status to the controller
  always_comb begin
    stat.sym_full = sym_r == hcb_pkg::CNT_W'(hcb_pkg::MAX_SYMBOLS);
    stat.i_zero   = i_r == '0;
    stat.up_less  = x_r.weight < h_rdata.weight;
    stat.cnt_gt1  = cnt_r > hcb_pkg::CNT_W'(1);
    stat.cnt_zero = cnt_r == '0;
    stat.l_out    = lidx >= cnt_r;
    stat.dn_stop  = !take_l && !take_r;
    stat.leaf     = hcb_pkg::CNT_W'(n_r) < sym_r;
    stat.sp_zero  = sp_r == '0;
    stat.out_free = out_free;
  end

  // Execute the current command
  always_comb begin
    cnt_nxt       = cnt_r;
    sym_nxt       = sym_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    next_nxt      = next_r;
    i_nxt         = i_r;
    x_nxt         = x_r;
    a_nxt         = a_r;
    top_nxt       = top_r;
    lv_nxt        = lv_r;
    n_nxt         = n_r;
    len_nxt       = len_r;
    code_nxt      = code_r;
    sp_nxt        = sp_r;
    out_data_nxt  = out_data_r;
    h_we          = 1'b0;
    h_waddr       = i_r;
    h_wdata       = x_r;
    h_raddr       = parent;
    c_we          = 1'b0;
    c_waddr       = merge_rel[hcb_pkg::IDX_W-1:0];
    c_wdata       = '{left: a_r.node, right: top_r.node};
    c_raddr       = child_rel[hcb_pkg::IDX_W-1:0];
    s_we          = 1'b0;
    s_waddr       = sp_r[hcb_pkg::IDX_W-1:0];
    s_wdata       = '{node: c_rdata.right, len: len_r + hcb_pkg::LEN_W'(1),
                      code: {code_r[hcb_pkg::CODE_W-2:0], 1'b1}};
    s_raddr       = sp_dec[hcb_pkg::IDX_W-1:0];
    unique case (cmd.op)
      hcb_pkg::OP_LOAD: begin
        x_nxt.node   = sym_r;
        x_nxt.weight = hcb_pkg::SUM_W'(in_data.weight[hcb_pkg::WEIGHT_BITS-1:0]);
        i_nxt        = cnt_r[hcb_pkg::IDX_W-1:0];
        cnt_nxt      = cnt_r + hcb_pkg::CNT_W'(1);
        sym_nxt      = sym_r + hcb_pkg::CNT_W'(1);
        next_nxt     = sym_r + hcb_pkg::CNT_W'(1);
      end
      hcb_pkg::OP_DROP: begin
        ovf_nxt  = 1'b1;
        next_nxt = sym_r;
      end
      hcb_pkg::OP_UP: begin
        // at the root the moving entry settles at once
        h_we    = i_r == '0;
        h_waddr = '0;
      end
      hcb_pkg::OP_UP_CMP: begin
        h_we = 1'b1;
        if (x_r.weight < h_rdata.weight) begin
          h_wdata = h_rdata;
          i_nxt   = parent;
        end
      end
      hcb_pkg::OP_POP0: begin
        h_raddr = '0;
        cnt_nxt = cnt_r - hcb_pkg::CNT_W'(1);
      end
      hcb_pkg::OP_POP1: begin
        if (cmd.first) begin
          a_nxt = h_rdata;
        end else begin
          top_nxt = h_rdata;
        end
        h_raddr = cnt_r[hcb_pkg::IDX_W-1:0];
      end
      hcb_pkg::OP_POP2: begin
        x_nxt = h_rdata;
        i_nxt = '0;
      end
      hcb_pkg::OP_DN: begin
        h_we    = lidx >= cnt_r;
        h_raddr = lidx[hcb_pkg::IDX_W-1:0];
      end
      hcb_pkg::OP_DN_L: begin
        lv_nxt  = h_rdata;
        h_raddr = ridx[hcb_pkg::IDX_W-1:0];
      end
      hcb_pkg::OP_DN_R: begin
        h_we = 1'b1;
        if (take_r) begin
          h_wdata = h_rdata;
          i_nxt   = ridx[hcb_pkg::IDX_W-1:0];
        end else if (take_l) begin
          h_wdata = lv_r;
          i_nxt   = lidx[hcb_pkg::IDX_W-1:0];
        end
      end
      hcb_pkg::OP_MERGE: begin
        c_we         = 1'b1;
        x_nxt.node   = next_r;
        x_nxt.weight = a_r.weight + top_r.weight;
        i_nxt        = cnt_r[hcb_pkg::IDX_W-1:0];
        cnt_nxt      = cnt_r + hcb_pkg::CNT_W'(1);
        next_nxt     = next_r + hcb_pkg::CNT_W'(1);
      end
      hcb_pkg::OP_WK_START: begin
        n_nxt    = top_r.node;
        len_nxt  = '0;
        code_nxt = '0;
        sp_nxt   = '0;
      end
      hcb_pkg::OP_EMIT: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.symbol       = n_r;
        out_data_nxt.code_bits    = 63'(code_r);
        out_data_nxt.code_len     = 6'(len_r);
        out_data_nxt.overflow     = ovf_r;
        out_data_nxt.end_of_codes = sp_r == '0;
        if (sp_r != '0) begin
          sp_nxt = sp_dec;
        end else begin
          // set finished: ready for the next one
          cnt_nxt = '0;
          sym_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      hcb_pkg::OP_CHILD_RD: begin
      end
      hcb_pkg::OP_WK_CH: begin
        // stack the right subtree, descend left
        s_we     = 1'b1;
        sp_nxt   = sp_r + hcb_pkg::CNT_W'(1);
        n_nxt    = c_rdata.left;
        len_nxt  = len_r + hcb_pkg::LEN_W'(1);
        code_nxt = {code_r[hcb_pkg::CODE_W-2:0], 1'b0};
      end
      hcb_pkg::OP_WK_POP: begin
        n_nxt    = s_rdata.node;
        len_nxt  = s_rdata.len;
        code_nxt = s_rdata.code;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sym_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      sym_r       <= sym_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    next_r     <= next_nxt;
    i_r        <= i_nxt;
    x_r        <= x_nxt;
    a_r        <= a_nxt;
    top_r      <= top_nxt;
    lv_r       <= lv_nxt;
    n_r        <= n_nxt;
    len_r      <= len_nxt;
    code_r     <= code_nxt;
    sp_r       <= sp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Min-heap of {node, weight}
  hcb_ram #(
    .WIDTH ($bits(hcb_pkg::heap_ent_t)),
    .DEPTH (hcb_pkg::MAX_SYMBOLS)
  ) u_heap (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // Children of internal nodes, addressed by node number minus leaf count
  hcb_ram #(
    .WIDTH ($bits(hcb_pkg::child_ent_t)),
    .DEPTH (hcb_pkg::CHILD_DEPTH)
  ) u_child (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // Pending right subtrees of the depth-first walk
  hcb_ram #(
    .WIDTH ($bits(hcb_pkg::walk_ent_t)),
    .DEPTH (hcb_pkg::MAX_SYMBOLS)
  ) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

endmodule

`default_nettype wire

### rtl/hcb_ctrl.sv
// Controller: sequences load, heap sift-up/down, tree merge and code walk.
// Depends on hcb_pkg; issues commands to hcb_dp and reads its status.
`default_nettype none

module hcb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_final,
  input  wire hcb_pkg::dp_stat_t stat,
  output logic                   in_stall,
  output hcb_pkg::dp_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP       = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_BUILD    = 4'd3;
  localparam logic [3:0] S_POP0     = 4'd4;
  localparam logic [3:0] S_POP1     = 4'd5;
  localparam logic [3:0] S_POP2     = 4'd6;
  localparam logic [3:0] S_DN       = 4'd7;
  localparam logic [3:0] S_DN_L     = 4'd8;
  localparam logic [3:0] S_DN_R     = 4'd9;
  localparam logic [3:0] S_MERGE    = 4'd10;
  localparam logic [3:0] S_WK_START = 4'd11;
  localparam logic [3:0] S_WK_NODE  = 4'd12;
  localparam logic [3:0] S_WK_CH    = 4'd13;
  localparam logic [3:0] S_WK_POP   = 4'd14;

  localparam logic [1:0] POP_A    = 2'd0;
  localparam logic [1:0] POP_B    = 2'd1;
  localparam logic [1:0] POP_ROOT = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic       build_r, build_nxt;   // a finished push returns to the merge loop
  logic [1:0] popsel_r, popsel_nxt;
  logic [3:0] push_done, pop_done;
  logic [1:0] popsel_after;

  assign push_done = build_r ? S_BUILD : S_IDLE;

  // Where a finished pop leads
  always_comb begin
    pop_done     = S_WK_START;
    popsel_after = popsel_r;
    unique case (popsel_r)
      POP_A: begin
        pop_done     = S_POP0;
        popsel_after = POP_B;
      end
      POP_B:    pop_done = S_MERGE;
      default:  pop_done = S_WK_START;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    build_nxt  = build_r;
    popsel_nxt = popsel_r;
    cmd.op     = hcb_pkg::OP_NONE;
    cmd.first  = popsel_r == POP_A;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (!stat.sym_full) begin
            cmd.op    = hcb_pkg::OP_LOAD;
            build_nxt = in_final;
            state_nxt = S_UP;
          end else begin
            cmd.op    = hcb_pkg::OP_DROP;
            build_nxt = in_final;
            state_nxt = in_final ? S_BUILD : S_IDLE;
          end
        end
      end
      S_UP: begin
        cmd.op    = hcb_pkg::OP_UP;
        state_nxt = stat.i_zero ? push_done : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.op    = hcb_pkg::OP_UP_CMP;
        state_nxt = stat.up_less ? S_UP : push_done;
      end
      S_BUILD: begin
        popsel_nxt = stat.cnt_gt1 ? POP_A : POP_ROOT;
        state_nxt  = S_POP0;
      end
      S_POP0: begin
        cmd.op    = hcb_pkg::OP_POP0;
        state_nxt = S_POP1;
      end
      S_POP1: begin
        cmd.op    = hcb_pkg::OP_POP1;
        state_nxt = S_POP2;
      end
      S_POP2: begin
        cmd.op = hcb_pkg::OP_POP2;
        if (stat.cnt_zero) begin
          state_nxt  = pop_done;
          popsel_nxt = popsel_after;
        end else begin
          state_nxt = S_DN;
        end
      end
      S_DN: begin
        cmd.op = hcb_pkg::OP_DN;
        if (stat.l_out) begin
          state_nxt  = pop_done;
          popsel_nxt = popsel_after;
        end else begin
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        cmd.op    = hcb_pkg::OP_DN_L;
        state_nxt = S_DN_R;
      end
      S_DN_R: begin
        cmd.op = hcb_pkg::OP_DN_R;
        if (stat.dn_stop) begin
          state_nxt  = pop_done;
          popsel_nxt = popsel_after;
        end else begin
          state_nxt = S_DN;
        end
      end
      S_MERGE: begin
        cmd.op    = hcb_pkg::OP_MERGE;
        state_nxt = S_UP;
      end
      S_WK_START: begin
        cmd.op    = hcb_pkg::OP_WK_START;
        state_nxt = S_WK_NODE;
      end
      S_WK_NODE: begin
        if (stat.leaf) begin
          // hold until the output register can take the code
          if (stat.out_free) begin
            cmd.op = hcb_pkg::OP_EMIT;
            if (stat.sp_zero) begin
              build_nxt = 1'b0;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_WK_POP;
            end
          end
        end else begin
          cmd.op    = hcb_pkg::OP_CHILD_RD;
          state_nxt = S_WK_CH;
        end
      end
      S_WK_CH: begin
        cmd.op    = hcb_pkg::OP_WK_CH;
        state_nxt = S_WK_NODE;
      end
      S_WK_POP: begin
        cmd.op    = hcb_pkg::OP_WK_POP;
        state_nxt = S_WK_NODE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      build_r  <= 1'b0;
      popsel_r <= POP_A;
    end else begin
      state_r  <= state_nxt;
      build_r  <= build_nxt;
      popsel_r <= popsel_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/huffman_code_builder.sv
// Top level of the Huffman code builder: controller plus datapath.
// Depends on hcb_pkg, hcb_ctrl, hcb_dp (and hcb_ram through it).
//
// Weights arrive one per transfer, symbols numbered by arrival; up to 32 are
// kept, later ones are dropped and flagged in overflow. Each kept weight is
// inserted into a min-heap held in a RAM with one write and one read port:
// the load is accepted, then the weight climbs the heap a level at a time
// (read the parent, compare and move) and settles. The transfer marked
// final_symbol starts the build: each merge pops two minima and pushes the
// sum, then a depth-first walk emits one code per leaf, waiting on out_stall
// while the output register is full. Input is stalled while each weight sifts
// up, and from the final transfer until the last code sits in the output
// register; no clearing pass is needed after reset.
`default_nettype none

module huffman_code_builder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire hcb_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hcb_pkg::out_item_t       out_data
);

  hcb_pkg::dp_cmd_t  cmd;
  hcb_pkg::dp_stat_t stat;

  hcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_final (in_data.final_symbol),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  hcb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/hcb_checker.sv
// Port-level checks for huffman_code_builder, attached by bind.
// Depends on hcb_pkg and the top-level port list.
`default_nettype none

module hcb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire hcb_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire hcb_pkg::out_item_t out_data
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The final transfer starts a build: input stalls next cycle
  a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.final_symbol |=> in_stall)
    else $error("input not stalled after final transfer");

  // Codes never exceed the deepest possible leaf
  a_code_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.code_bits[62:31] == '0 && out_data.code_len[5] == 1'b0)
    else $error("code wider than tree depth");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
